// ===== rtl/scfp_pkg.sv =====
// Shared types and constants of the serial command frame parser.
// Depends on nothing; every other file of the block uses it.
package scfp_pkg;

	localparam int ByteW   = 8;
	localparam int CfgIdxW = 8;
	localparam int StatusW = 3;

	localparam logic [CfgIdxW-1:0] REG_FRAME_IDENTIFIER = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] REG_OPCODE_START_ADV = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] REG_OPCODE_STOP_ADV  = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] REG_OPCODE_DATA      = CfgIdxW'(3);

	localparam logic [ByteW-1:0] RST_FRAME_IDENTIFIER = ByteW'(0);
	localparam logic [ByteW-1:0] RST_OPCODE_START_ADV = ByteW'(1);
	localparam logic [ByteW-1:0] RST_OPCODE_STOP_ADV  = ByteW'(2);
	localparam logic [ByteW-1:0] RST_OPCODE_DATA      = ByteW'(3);

	typedef enum logic [1:0] {
		PH_IDENT   = 2'd0,
		PH_OPCODE  = 2'd1,
		PH_LENGTH  = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef enum logic [StatusW-1:0] {
		ST_HEADER  = 3'd0,
		ST_DROPPED = 3'd1,
		ST_BADOP   = 3'd2,
		ST_LENGTH  = 3'd3,
		ST_PAYLOAD = 3'd4
	} status_t;

	typedef struct packed {
		logic [ByteW-1:0] frame_identifier;
		logic [ByteW-1:0] opcode_start_adv;
		logic [ByteW-1:0] opcode_stop_adv;
		logic [ByteW-1:0] opcode_data;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic [ByteW-1:0] payload_byte;
		logic [ByteW-1:0] payload_index;
		logic [ByteW-1:0] frame_opcode;
		logic [ByteW-1:0] frame_length;
		logic             frame_done;
	} res_t;

endpackage

// ===== rtl/scfp_if.sv =====
// Valid/ready channel interfaces of the serial command frame parser.
// Depends on scfp_pkg for field widths.
interface scfp_rx_if;
	logic                      valid;
	logic                      ready;
	logic [scfp_pkg::ByteW-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfp_res_if;
	logic                        valid;
	logic                        ready;
	logic [scfp_pkg::StatusW-1:0] status;
	logic [scfp_pkg::ByteW-1:0]   payload_byte;
	logic [scfp_pkg::ByteW-1:0]   payload_index;
	logic [scfp_pkg::ByteW-1:0]   frame_opcode;
	logic [scfp_pkg::ByteW-1:0]   frame_length;
	logic                         frame_done;

	modport source (output valid, output status, output payload_byte, output payload_index,
		output frame_opcode, output frame_length, output frame_done, input ready);
	modport sink (input valid, input status, input payload_byte, input payload_index,
		input frame_opcode, input frame_length, input frame_done, output ready);
endinterface

// ===== rtl/scfp_cfg_regs.sv =====
// Configuration register file: frame identifier and the three opcode values.
// Depends on scfp_pkg.
module scfp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [scfp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [scfp_pkg::ByteW-1:0]    cfg_wdata,
	output scfp_pkg::cfg_t                cfg
);

	scfp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_identifier <= scfp_pkg::RST_FRAME_IDENTIFIER;
			cfg_q.opcode_start_adv <= scfp_pkg::RST_OPCODE_START_ADV;
			cfg_q.opcode_stop_adv  <= scfp_pkg::RST_OPCODE_STOP_ADV;
			cfg_q.opcode_data      <= scfp_pkg::RST_OPCODE_DATA;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scfp_pkg::REG_FRAME_IDENTIFIER: cfg_q.frame_identifier <= cfg_wdata;
				scfp_pkg::REG_OPCODE_START_ADV: cfg_q.opcode_start_adv <= cfg_wdata;
				scfp_pkg::REG_OPCODE_STOP_ADV:  cfg_q.opcode_stop_adv  <= cfg_wdata;
				scfp_pkg::REG_OPCODE_DATA:      cfg_q.opcode_data      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/scfp_parse_core.sv =====
// Frame parsing state machine: phase, held opcode, length and payload count.
// Computes one result per stepped byte. Depends on scfp_pkg.
module scfp_parse_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [scfp_pkg::ByteW-1:0] rx_byte,
	input  scfp_pkg::cfg_t             cfg,
	output scfp_pkg::res_t             res
);

	scfp_pkg::phase_t           phase_q, phase_d;
	logic [scfp_pkg::ByteW-1:0] held_opcode_q, held_opcode_d;
	logic [scfp_pkg::ByteW-1:0] held_length_q, held_length_d;
	logic [scfp_pkg::ByteW-1:0] bytes_seen_q, bytes_seen_d;
	logic [scfp_pkg::ByteW-1:0] bytes_next;
	logic                       ident_hit;
	logic                       opcode_ok;
	logic                       last_payload;

	assign ident_hit    = (rx_byte == cfg.frame_identifier);
	assign opcode_ok    = (rx_byte == cfg.opcode_start_adv) || (rx_byte == cfg.opcode_stop_adv)
		|| (rx_byte == cfg.opcode_data);
	assign bytes_next   = bytes_seen_q + scfp_pkg::ByteW'(1);
	assign last_payload = (bytes_next >= held_length_q);

	always_comb begin
		phase_d       = phase_q;
		held_opcode_d = held_opcode_q;
		held_length_d = held_length_q;
		bytes_seen_d  = bytes_seen_q;
		unique case (phase_q)
			scfp_pkg::PH_IDENT: begin
				if (ident_hit) begin
					held_opcode_d = '0;
					held_length_d = '0;
					bytes_seen_d  = '0;
					phase_d       = scfp_pkg::PH_OPCODE;
				end
			end
			scfp_pkg::PH_OPCODE: begin
				if (opcode_ok) begin
					held_opcode_d = rx_byte;
					phase_d       = scfp_pkg::PH_LENGTH;
				end else begin
					phase_d = scfp_pkg::PH_IDENT;
				end
			end
			scfp_pkg::PH_LENGTH: begin
				held_length_d = rx_byte;
				bytes_seen_d  = '0;
				phase_d       = (rx_byte == '0) ? scfp_pkg::PH_IDENT : scfp_pkg::PH_PAYLOAD;
			end
			scfp_pkg::PH_PAYLOAD: begin
				bytes_seen_d = bytes_next;
				if (last_payload) begin
					phase_d = scfp_pkg::PH_IDENT;
				end
			end
			default: phase_d = scfp_pkg::PH_IDENT;
		endcase
	end

	always_comb begin
		res = '{status: scfp_pkg::ST_DROPPED, default: '0};
		unique case (phase_q)
			scfp_pkg::PH_IDENT: begin
				res.status = ident_hit ? scfp_pkg::ST_HEADER : scfp_pkg::ST_DROPPED;
			end
			scfp_pkg::PH_OPCODE: begin
				res.status       = opcode_ok ? scfp_pkg::ST_HEADER : scfp_pkg::ST_BADOP;
				res.frame_opcode = rx_byte;
			end
			scfp_pkg::PH_LENGTH: begin
				res.status       = scfp_pkg::ST_LENGTH;
				res.frame_opcode = held_opcode_q;
				res.frame_length = rx_byte;
				res.frame_done   = (rx_byte == '0);
			end
			scfp_pkg::PH_PAYLOAD: begin
				res.status        = scfp_pkg::ST_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = bytes_seen_q;
				res.frame_opcode  = held_opcode_q;
				res.frame_length  = held_length_q;
				res.frame_done    = last_payload;
			end
			default: res.status = scfp_pkg::ST_DROPPED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= scfp_pkg::PH_IDENT;
			held_opcode_q <= '0;
			held_length_q <= '0;
			bytes_seen_q  <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			held_opcode_q <= held_opcode_d;
			held_length_q <= held_length_d;
			bytes_seen_q  <= bytes_seen_d;
		end
	end

	a_payload_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == scfp_pkg::PH_PAYLOAD |-> held_length_q != '0)
		else $error("payload phase with zero held length");

	a_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == scfp_pkg::PH_PAYLOAD |-> bytes_seen_q < held_length_q)
		else $error("payload count reached declared length");

	a_done_to_ident: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.frame_done |=> phase_q == scfp_pkg::PH_IDENT)
		else $error("completed frame did not return to identifier search");

endmodule

// ===== rtl/serial_command_frame_parser.sv =====
// Serial command frame parser: one result per received byte, one byte per clock
// while results are taken. A byte is accepted into an input register, decoded
// against the parse state and registered into the result register, which raises
// res valid; one byte per cycle sustained while the result register keeps being
// taken. rx stalls only while the input register holds a byte and the result
// register is full and not being taken.
// Depends on scfp_pkg, scfp_if, scfp_cfg_regs and scfp_parse_core.
module serial_command_frame_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [scfp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [scfp_pkg::ByteW-1:0]    cfg_wdata,
	scfp_rx_if.sink                       rx,
	scfp_res_if.source                    res
);

	scfp_pkg::cfg_t             cfg;
	scfp_pkg::res_t             res_comb;
	scfp_pkg::res_t             res_s2;
	logic                       valid_s1;
	logic [scfp_pkg::ByteW-1:0] byte_s1;
	logic                       valid_s2;
	logic                       advance;

	assign advance  = valid_s1 && (!valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || advance;

	scfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	scfp_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign res.valid         = valid_s2;
	assign res.status        = res_s2.status;
	assign res.payload_byte  = res_s2.payload_byte;
	assign res.payload_index = res_s2.payload_index;
	assign res.frame_opcode  = res_s2.frame_opcode;
	assign res.frame_length  = res_s2.frame_length;
	assign res.frame_done    = res_s2.frame_done;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a byte while stalled");

	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.frame_done |->
		res_s2.status == scfp_pkg::ST_LENGTH || res_s2.status == scfp_pkg::ST_PAYLOAD)
		else $error("frame done on a header or dropped byte");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status == scfp_pkg::ST_PAYLOAD |->
		res_s2.payload_index < res_s2.frame_length)
		else $error("payload index outside declared length");

endmodule

// ===== tb/scfp_tb_pkg.sv =====
// Frame tracker for the serial command frame parser testbench: mirrors the
// parse state and register values and keeps the results still owed by the block.
// Depends on scfp_pkg.
package scfp_tb_pkg;

	typedef logic [scfp_pkg::ByteW-1:0] byte_t;

	class frame_tracker;
		byte_t             ident;
		byte_t             op_start;
		byte_t             op_stop;
		byte_t             op_data;
		scfp_pkg::phase_t  phase;
		byte_t             held_op;
		byte_t             held_len;
		byte_t             taken;
		scfp_pkg::res_t    awaited[$];
		int                errors;

		function new();
			ident    = scfp_pkg::RST_FRAME_IDENTIFIER;
			op_start = scfp_pkg::RST_OPCODE_START_ADV;
			op_stop  = scfp_pkg::RST_OPCODE_STOP_ADV;
			op_data  = scfp_pkg::RST_OPCODE_DATA;
			phase    = scfp_pkg::PH_IDENT;
			held_op  = '0;
			held_len = '0;
			taken    = '0;
			errors   = 0;
		endfunction

		function void set_register(logic [scfp_pkg::CfgIdxW-1:0] idx, byte_t val);
			case (idx)
				scfp_pkg::REG_FRAME_IDENTIFIER: ident = val;
				scfp_pkg::REG_OPCODE_START_ADV: op_start = val;
				scfp_pkg::REG_OPCODE_STOP_ADV:  op_stop = val;
				scfp_pkg::REG_OPCODE_DATA:      op_data = val;
				default: ;
			endcase
		endfunction

		function void take_byte(byte_t b);
			scfp_pkg::res_t r;
			r = '0;
			r.status = scfp_pkg::ST_DROPPED;
			case (phase)
				scfp_pkg::PH_IDENT: begin
					if (b == ident) begin
						r.status = scfp_pkg::ST_HEADER;
						held_op  = '0;
						held_len = '0;
						taken    = '0;
						phase    = scfp_pkg::PH_OPCODE;
					end
				end
				scfp_pkg::PH_OPCODE: begin
					r.frame_opcode = b;
					if (b == op_start || b == op_stop || b == op_data) begin
						r.status = scfp_pkg::ST_HEADER;
						held_op  = b;
						phase    = scfp_pkg::PH_LENGTH;
					end else begin
						r.status = scfp_pkg::ST_BADOP;
						phase    = scfp_pkg::PH_IDENT;
					end
				end
				scfp_pkg::PH_LENGTH: begin
					r.status       = scfp_pkg::ST_LENGTH;
					r.frame_opcode = held_op;
					r.frame_length = b;
					held_len       = b;
					taken          = '0;
					if (b == '0) begin
						r.frame_done = 1'b1;
						phase        = scfp_pkg::PH_IDENT;
					end else begin
						phase = scfp_pkg::PH_PAYLOAD;
					end
				end
				default: begin
					r.status        = scfp_pkg::ST_PAYLOAD;
					r.payload_byte  = b;
					r.payload_index = taken;
					r.frame_opcode  = held_op;
					r.frame_length  = held_len;
					taken           = taken + byte_t'(1);
					if (taken >= held_len) begin
						r.frame_done = 1'b1;
						phase        = scfp_pkg::PH_IDENT;
					end
				end
			endcase
			awaited.push_back(r);
		endfunction

		function void match_result(scfp_pkg::res_t got);
			scfp_pkg::res_t exp;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with no transaction outstanding: status %0d byte %h",
						$realtime, got.status, got.payload_byte);
				return;
			end
			exp = awaited.pop_front();
			if (got.status !== exp.status || got.payload_byte !== exp.payload_byte ||
					got.payload_index !== exp.payload_index ||
					got.frame_opcode !== exp.frame_opcode ||
					got.frame_length !== exp.frame_length ||
					got.frame_done !== exp.frame_done) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: result mismatch", $realtime);
					$display("  expected status %0d byte %h index %0d opcode %h length %0d done %b",
						exp.status, exp.payload_byte, exp.payload_index, exp.frame_opcode,
						exp.frame_length, exp.frame_done);
					$display("  actual   status %0d byte %h index %0d opcode %h length %0d done %b",
						got.status, got.payload_byte, got.payload_index, got.frame_opcode,
						got.frame_length, got.frame_done);
				end
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		function bit clean();
			return errors == 0 && awaited.size() == 0;
		endfunction
	endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench of the serial command frame parser: directed and random
// byte streams under several register settings, with random stalls on both sides.
// Depends on scfp_pkg, scfp_if, scfp_tb_pkg and the parser RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxGap     = 18;
	localparam int HoldAt     = 400;
	localparam int HoldLen    = 300;
	localparam int PhaseItems = 180;
	localparam int NumPhases  = 6;
	localparam int MaxLen     = 255;

	localparam logic [scfp_pkg::CfgIdxW-1:0] REG_BEYOND_LIST = scfp_pkg::CfgIdxW'(4);
	localparam logic [scfp_pkg::CfgIdxW-1:0] REG_TOP_INDEX   = scfp_pkg::CfgIdxW'(255);

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we;
	logic [scfp_pkg::CfgIdxW-1:0]  cfg_index;
	logic [scfp_pkg::ByteW-1:0]    cfg_wdata;

	bit                            tx_calm;
	bit                            rx_calm;
	bit                            sink_holding;
	scfp_tb_pkg::byte_t            reg_value [4];
	scfp_tb_pkg::frame_tracker     book;

	scfp_rx_if  rx_ch ();
	scfp_res_if res_ch ();

	serial_command_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	always #5 clk = ~clk;

	initial begin
		#3ms;
		$display("FAIL serial_command_frame_parser");
		$finish;
	end

	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, MaxGap);
	endfunction

	function automatic scfp_tb_pkg::byte_t any_byte();
		return scfp_tb_pkg::byte_t'($urandom_range(0, 255));
	endfunction

	task automatic send_byte(input scfp_tb_pkg::byte_t b);
		int gap;
		gap = sink_holding ? 0 : draw_gap(tx_calm);
		@(negedge clk);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		book.take_byte(b);
	endtask

	task automatic write_reg(input logic [scfp_pkg::CfgIdxW-1:0] idx,
			input scfp_tb_pkg::byte_t val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		book.set_register(idx, val);
		if (idx <= scfp_pkg::REG_OPCODE_DATA)
			reg_value[idx[1:0]] = val;
	endtask

	task automatic set_config(input scfp_tb_pkg::byte_t ident, input scfp_tb_pkg::byte_t a,
			input scfp_tb_pkg::byte_t b, input scfp_tb_pkg::byte_t c);
		write_reg(scfp_pkg::REG_FRAME_IDENTIFIER, ident);
		write_reg(scfp_pkg::REG_OPCODE_START_ADV, a);
		write_reg(scfp_pkg::REG_OPCODE_STOP_ADV, b);
		write_reg(scfp_pkg::REG_OPCODE_DATA, c);
	endtask

	task automatic drain();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (book.outstanding() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_frame(input int fixed_len, output int n);
		scfp_tb_pkg::byte_t op;
		int                 r;
		int                 len;
		r = $urandom_range(0, 99);
		if (r < 8)
			op = any_byte();
		else
			op = reg_value[2'(int'(scfp_pkg::REG_OPCODE_START_ADV) + r % 3)];
		r = $urandom_range(0, 99);
		if (fixed_len >= 0)
			len = fixed_len;
		else if (r < 10)
			len = 0;
		else if (r < 90)
			len = $urandom_range(1, 8);
		else
			len = $urandom_range(9, 40);
		send_byte(reg_value[2'(scfp_pkg::REG_FRAME_IDENTIFIER)]);
		send_byte(op);
		send_byte(scfp_tb_pkg::byte_t'(len));
		for (int i = 0; i < len; i++)
			send_byte(any_byte());
		n = 3 + len;
	endtask

	task automatic send_partial();
		int k;
		k = $urandom_range(1, 4);
		send_byte(reg_value[2'(scfp_pkg::REG_FRAME_IDENTIFIER)]);
		if (k > 1)
			send_byte(reg_value[2'(scfp_pkg::REG_OPCODE_START_ADV)]);
		if (k > 2)
			send_byte(scfp_tb_pkg::byte_t'(4));
		if (k > 3)
			send_byte(any_byte());
	endtask

	task automatic run_random(input int target, input bit with_long);
		int sent;
		int n;
		sent = 0;
		if (with_long) begin
			send_frame(MaxLen, n);
			sent += n;
		end
		while (sent < target) begin
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 3)) send_byte(any_byte());
			end else begin
				send_frame(-1, n);
				sent += n;
			end
		end
		send_partial();
	endtask

	task automatic send_directed();
		scfp_tb_pkg::byte_t seq [18] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00,
			8'h02, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h03, 8'h01, 8'hA5, 8'h00, 8'h00, 8'h7F};
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	initial begin : result_sink
		int             stall;
		int             count;
		scfp_pkg::res_t got;
		count = 0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = (count == HoldAt) ? HoldLen : draw_gap(rx_calm);
			@(negedge clk);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				sink_holding = (count == HoldAt);
				repeat (stall) @(negedge clk);
				sink_holding = 1'b0;
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			got.status        = scfp_pkg::status_t'(res_ch.status);
			got.payload_byte  = res_ch.payload_byte;
			got.payload_index = res_ch.payload_index;
			got.frame_opcode  = res_ch.frame_opcode;
			got.frame_length  = res_ch.frame_length;
			got.frame_done    = res_ch.frame_done;
			book.match_result(got);
			count++;
		end
	end

	initial begin : stimulus
		book          = new();
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		reg_value[2'(scfp_pkg::REG_FRAME_IDENTIFIER)] = scfp_pkg::RST_FRAME_IDENTIFIER;
		reg_value[2'(scfp_pkg::REG_OPCODE_START_ADV)] = scfp_pkg::RST_OPCODE_START_ADV;
		reg_value[2'(scfp_pkg::REG_OPCODE_STOP_ADV)]  = scfp_pkg::RST_OPCODE_STOP_ADV;
		reg_value[2'(scfp_pkg::REG_OPCODE_DATA)]      = scfp_pkg::RST_OPCODE_DATA;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_directed();
		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				1: begin
					set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
					write_reg(REG_BEYOND_LIST, 8'h55);
					write_reg(REG_TOP_INDEX, 8'hAA);
				end
				2: set_config(8'h00, 8'h00, 8'h00, 8'hFF);
				4: set_config(8'h7E, 8'h10, 8'h20, 8'h30);
				3, 5: set_config(any_byte(), any_byte(), any_byte(), any_byte());
				default: ;
			endcase
			run_random(PhaseItems, p == 0);
			drain();
		end
		repeat (10) @(posedge clk);

		if (book.clean())
			$display("PASS serial_command_frame_parser");
		else
			$display("FAIL serial_command_frame_parser");
		$finish;
	end

endmodule
